/* rtl/core/bds_pkg.sv */
// shared constants and types of the 2x2 box downsample and int8 quantiser
// no dependencies; imported by every module of the block
package bds_pkg;

    // source frame geometry
    localparam int SRC_WIDTH  = 192;
    localparam int SRC_HEIGHT = 192;

    // counters and line store
    localparam int COL_W        = $clog2(SRC_WIDTH);
    localparam int ROW_W        = $clog2(SRC_HEIGHT);
    localparam int IDX_W        = COL_W - 1;
    localparam int STORE_DEPTH  = SRC_WIDTH / 2;
    localparam int ADDR_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int LAST_OUT_COL = (SRC_WIDTH / 2) * 2 - 1;
    localparam int LAST_OUT_ROW = (SRC_HEIGHT / 2) * 2 - 1;

    // channel widths
    localparam int PIX_W  = 8;
    localparam int PAIR_W = PIX_W + 1;
    localparam int SUM_W  = PIX_W + 2;

    // fixed point quantiser
    localparam int GAIN_W     = 32;
    localparam int FRAC_BITS  = 24;
    localparam int ZERO_W     = 8;
    localparam int DIFF_W     = SUM_W + 1;
    localparam int PROD_W     = DIFF_W + GAIN_W + 1;
    localparam int QUOT_W     = PROD_W - FRAC_BITS + 1;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd4210752;
    localparam logic signed [DIFF_W-1:0] SUM_MID = 11'sd510;

    // job queue between front and back
    localparam int JOB_DEPTH = 4;
    localparam int JPTR_W    = $clog2(JOB_DEPTH);

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_GAIN = 1'b0,
        CFG_ZERO = 1'b1
    } cfg_index_t;

    // one 2x2 block sum on its way to the quantiser
    typedef struct packed {
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
        logic             last;
    } job_t;

endpackage

/* rtl/core/box_downsample_int8_quantize_unit.sv */
// top level of the 2x2 box downsample with int8 affine quantisation
// depends on bds_pkg, bds_front, bds_job_fifo and bds_quant
//
//  channel   handshake            word
//  pixel in  push / full          red_in, green_in, blue_in
//  result    pop / empty          red_q, green_q, blue_q, frame_last
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one source pixel is taken per clock while the job queue has room; a result
// reaches the result ports from the edge that takes the odd-row odd-column pixel
// completing its block through the queue write, the multiplier stage and the
// rounding stage. the pixel side stalls only when the four-word job queue is
// full; the result side holds its word until pop.
// reset returns the counters to the top-left pixel and restores the registers;
// the line store needs no clearing as each odd row reads only its own even row.
module box_downsample_int8_quantize_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        red_in,
    input  logic [7:0]                        green_in,
    input  logic [7:0]                        blue_in,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [7:0]                 red_q,
    output logic signed [7:0]                 green_q,
    output logic signed [7:0]                 blue_q,
    output logic                              frame_last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  bds_pkg::cfg_index_t               cfg_index,
    input  logic [bds_pkg::GAIN_W-1:0]        cfg_data
);
    import bds_pkg::*;

    logic [GAIN_W-1:0]         gain_reg;
    logic signed [ZERO_W-1:0]  zero_reg;
    job_t                      front_job;
    job_t                      head_job;
    logic                      job_push;
    logic                      job_full;
    logic                      job_pop;
    logic                      job_empty;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
            zero_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GAIN: gain_reg <= cfg_data;
                CFG_ZERO: zero_reg <= cfg_data[ZERO_W-1:0];
                default:  gain_reg <= gain_reg;
            endcase
        end
    end

    // front end
    bds_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .red_in   (red_in),
        .green_in (green_in),
        .blue_in  (blue_in),
        .job      (front_job),
        .job_push (job_push),
        .job_full (job_full)
    );

    // job queue
    bds_job_fifo u_job_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (front_job),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (head_job),
        .empty   (job_empty)
    );

    // quantiser
    bds_quant u_quant (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (head_job),
        .job_empty  (job_empty),
        .job_pop    (job_pop),
        .gain       (gain_reg),
        .zero_off   (zero_reg),
        .empty      (empty),
        .pop        (pop),
        .red_q      (red_q),
        .green_q    (green_q),
        .blue_q     (blue_q),
        .frame_last (frame_last)
    );

endmodule

/* rtl/core/bds_front.sv */
// front end: pixel counters, pair sums, line store and 2x2 block sums
// depends on bds_pkg; pushes one job per output pixel into the job queue
module bds_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [7:0]              red_in,
    input  logic [7:0]              green_in,
    input  logic [7:0]              blue_in,
    output bds_pkg::job_t           job,
    output logic                    job_push,
    input  logic                    job_full
);
    import bds_pkg::*;

    logic [COL_W-1:0]        col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic [3*PIX_W-1:0]      hold_reg;
    logic [3*PAIR_W-1:0]     rd_data_reg;
    logic [3*PAIR_W-1:0]     store_mem [STORE_DEPTH];
    logic                    accept;
    logic                    col_odd;
    logic                    row_odd;
    logic [IDX_W-1:0]        idx;
    logic                    in_range;
    logic [PAIR_W-1:0]       pair_red, pair_green, pair_blue;

    // handshake
    assign full    = job_full;
    assign accept  = push & ~job_full;
    assign col_odd = col_reg[0];
    assign row_odd = row_reg[0];
    assign idx     = col_reg[COL_W-1:1];
    assign in_range = ({1'b0, idx} < (IDX_W+1)'(STORE_DEPTH));

    // horizontal pair sums
    assign pair_red   = {1'b0, hold_reg[PIX_W-1:0]}         + {1'b0, red_in};
    assign pair_green = {1'b0, hold_reg[2*PIX_W-1:PIX_W]}   + {1'b0, green_in};
    assign pair_blue  = {1'b0, hold_reg[3*PIX_W-1:2*PIX_W]} + {1'b0, blue_in};

    // block sums with the pair from the row above
    assign job.sum_red   = {1'b0, rd_data_reg[PAIR_W-1:0]} + {1'b0, pair_red};
    assign job.sum_green = {1'b0, rd_data_reg[2*PAIR_W-1:PAIR_W]} + {1'b0, pair_green};
    assign job.sum_blue  = {1'b0, rd_data_reg[3*PAIR_W-1:2*PAIR_W]} + {1'b0, pair_blue};
    assign job.last      = (row_reg == ROW_W'(LAST_OUT_ROW)) &&
                           (col_reg == COL_W'(LAST_OUT_COL));
    assign job_push      = accept & col_odd & row_odd;

    // position counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_reg == COL_W'(SRC_WIDTH - 1))
            begin
                col_next = '0;
                if (row_reg == ROW_W'(SRC_HEIGHT - 1))
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // even column pixel held for its partner
    always_ff @(posedge clk)
    begin
        if (accept && !col_odd)
        begin
            hold_reg <= {blue_in, green_in, red_in};
        end
    end

    // line store: written on even rows, read one pixel ahead on odd rows
    always_ff @(posedge clk)
    begin
        if (accept && col_odd && !row_odd && in_range)
        begin
            store_mem[idx[ADDR_W-1:0]] <= {pair_blue, pair_green, pair_red};
        end
        if (accept && !col_odd && row_odd && in_range)
        begin
            rd_data_reg <= store_mem[idx[ADDR_W-1:0]];
        end
    end

endmodule

/* rtl/core/bds_job_fifo.sv */
// short job queue between front end and quantiser
// depends on bds_pkg for the job word and depth
module bds_job_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  bds_pkg::job_t  wr_data,
    output logic           full,
    input  logic           rd_en,
    output bds_pkg::job_t  rd_data,
    output logic           empty
);
    import bds_pkg::*;

    job_t                 slot_reg [JOB_DEPTH];
    logic [JPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [JPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [JPTR_W:0]      count_reg, count_next;
    logic                 do_wr, do_rd;

    assign full    = (count_reg == (JPTR_W+1)'(JOB_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & ~empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_wr ? JPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? JPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/core/bds_quant.sv */
// back end: two stage int8 affine quantiser, one lane per channel
// depends on bds_pkg; stage two registers drive the result ports
module bds_quant (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bds_pkg::job_t                       job,
    input  logic                                job_empty,
    output logic                                job_pop,
    input  logic [bds_pkg::GAIN_W-1:0]          gain,
    input  logic signed [bds_pkg::ZERO_W-1:0]   zero_off,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [7:0]                   red_q,
    output logic signed [7:0]                   green_q,
    output logic signed [7:0]                   blue_q,
    output logic                                frame_last
);
    import bds_pkg::*;

    logic signed [PROD_W-1:0]  prod_reg [3];
    logic signed [PROD_W-1:0]  prod_next [3];
    logic                      last1_reg;
    logic                      s1_valid_reg, s1_valid_next;
    logic signed [7:0]         q_reg [3];
    logic signed [7:0]         q_next [3];
    logic                      last2_reg;
    logic                      s2_valid_reg, s2_valid_next;
    logic                      s1_ready, s2_ready;
    logic [SUM_W-1:0]          sums [3];

    assign sums[0] = job.sum_red;
    assign sums[1] = job.sum_green;
    assign sums[2] = job.sum_blue;

    // stage flow control
    assign s2_ready = ~s2_valid_reg | pop;
    assign s1_ready = ~s1_valid_reg | s2_ready;
    assign job_pop  = s1_ready & ~job_empty;
    assign s1_valid_next = job_pop ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_reg);
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    // stage one: centre the sum and multiply by the gain
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            prod_next[ch] = PROD_W'(($signed({1'b0, sums[ch]}) - SUM_MID) *
                                    $signed({1'b0, gain}));
        end
    end

    // stage two: add zero point, round half to even, saturate
    always_comb
    begin
        logic signed [QUOT_W-1:0]  quot;
        logic [FRAC_BITS-1:0]      rem;
        logic                      up;
        for (int ch = 0; ch < 3; ch++)
        begin
            rem  = prod_reg[ch][FRAC_BITS-1:0];
            quot = QUOT_W'($signed(prod_reg[ch][PROD_W-1:FRAC_BITS])) + QUOT_W'(zero_off);
            up   = (rem > {1'b1, {(FRAC_BITS-1){1'b0}}}) ||
                   ((rem == {1'b1, {(FRAC_BITS-1){1'b0}}}) && quot[0]);
            quot = quot + QUOT_W'(up);
            priority if (quot < -QUOT_W'(128))
            begin
                q_next[ch] = -8'sd128;
            end
            else if (quot > QUOT_W'(127))
            begin
                q_next[ch] = 8'sd127;
            end
            else
            begin
                q_next[ch] = quot[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                prod_reg[ch] <= prod_next[ch];
            end
            last1_reg <= job.last;
        end
        if (s2_ready && s1_valid_reg)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                q_reg[ch] <= q_next[ch];
            end
            last2_reg <= last1_reg;
        end
    end

    // result word
    assign empty      = ~s2_valid_reg;
    assign red_q      = q_reg[0];
    assign green_q    = q_reg[1];
    assign blue_q     = q_reg[2];
    assign frame_last = last2_reg;

endmodule
